@@ design/tcp_segmenter_checksum_unit_assert.svh @@
// Assertion macros for the TCP segmenter checksum unit.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef TCP_SEGMENTER_CHECKSUM_UNIT_ASSERT_SVH
`define TCP_SEGMENTER_CHECKSUM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tsc_pkg.sv @@
// Shared types, constants and checksum helpers of the TCP segmenter checksum unit.
// No dependencies.
package tsc_pkg;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_ADDR = 3'd0,
        CFG_DST_ADDR = 3'd1,
        CFG_SRC_PORT = 3'd2,
        CFG_DST_PORT = 3'd3,
        CFG_LINK_MTU = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] IP_VER_IHL    = 16'h4500;
    localparam logic [15:0] IP_TTL_PROTO  = 16'h4006;
    localparam logic [15:0] TCP_PROTO     = 16'd6;
    localparam logic [15:0] MSS_KIND_LEN  = 16'h0204;
    localparam logic [15:0] MTU_MIN       = 16'd576;
    localparam logic [15:0] MTU_DEFAULT   = 16'd1500;
    localparam logic [15:0] IP_HDR_LEN    = 16'd20;
    localparam logic [15:0] TCP_HDR_BASE  = 16'd20;
    localparam logic [15:0] TCP_HDR_OPT   = 16'd24;
    localparam logic [15:0] HDRS_BASE     = IP_HDR_LEN + TCP_HDR_BASE;
    localparam logic [15:0] HDRS_OPT      = IP_HDR_LEN + TCP_HDR_OPT;
    localparam logic [2:0]  DOFF_BASE     = 3'd5;
    localparam logic [2:0]  DOFF_OPT      = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        last_byte;
        logic [31:0] start_sequence;
        logic [31:0] ack_number;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] window_size;
        logic        add_mss_option;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_byte_present;
        logic        segment_end;
        logic        message_end;
        logic [15:0] ip_total_length;
        logic [15:0] ip_header_checksum;
        logic [15:0] tcp_checksum;
        logic [31:0] segment_sequence;
        logic [2:0]  data_offset_words;
        logic [15:0] mss_value;
    } result_t;

    // Item plus the raw sum of its per-message header words (ack, window, flags).
    typedef struct packed {
        item_t       item;
        logic [17:0] word_sum;
    } stage_t;

    // Values derived from the configuration registers.
    typedef struct packed {
        logic [15:0] addr_sum;
        logic [15:0] port_sum;
        logic [15:0] mp_base;
        logic [15:0] mp_opt;
    } cfg_view_t;

    // Fold a raw sum of 16-bit words into a 16-bit ones'-complement sum.
    function automatic logic [15:0] fold20(input logic [19:0] s);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, s[15:0]} + {13'h0, s[19:16]};
        u = {1'b0, t[15:0]} + {16'h0, t[16]};
        return u[15:0];
    endfunction

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'h0, t[16]};
    endfunction

    function automatic logic [15:0] mtu_eff(input logic [15:0] mtu);
        return (mtu >= MTU_MIN) ? mtu : MTU_DEFAULT;
    endfunction

endpackage

@@ design/tcp_segmenter_checksum_unit.sv @@
// Top level of the TCP segmenter checksum unit: input register, segment core, config.
// Depends on tsc_pkg, tsc_in_reg, tsc_seg_core, tsc_cfg_regs and the assertion header.
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   item (tsc_pkg::item_t)
//   result    result_valid / result_stall  result (tsc_pkg::result_t)
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per clock while result_stall is low; an item passes the input register,
// then the result register. The rate is set by the segment state update in the core.
// Reset clears control state (first_reg comes up set); link MTU comes up as 1500.
// A stalled result holds the core and, once the input register is full, the input.
// Config writes are always accepted; cfg_ready is tied high.
`include "tcp_segmenter_checksum_unit_assert.svh"

module tcp_segmenter_checksum_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  tsc_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output tsc_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic               stage_valid;
    tsc_pkg::stage_t    stage;
    tsc_pkg::cfg_view_t cfg_view;
    logic               out_free;
    logic               core_fire;
    logic               result_valid_reg, result_valid_next;

    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;
    assign core_fire = stage_valid && out_free;

    tsc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .write (cfg_valid && cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .view  (cfg_view)
    );

    tsc_in_reg u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .out_free    (out_free),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    tsc_seg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .stage  (stage),
        .cfg    (cfg_view),
        .result (result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (core_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    `TSC_ASSERT_NOW(a_open_segment_quiet, result_valid && !result.segment_end,
        result.message_end == 1'b0 && result.ip_total_length == 16'h0
            && result.tcp_checksum == 16'h0,
        "summary fields set on a transaction that does not close a segment")
    `TSC_ASSERT_NOW(a_stall_only_when_full, item_stall,
        stage_valid && result_valid && result_stall,
        "input stalled while the pipeline has room")
    `TSC_ASSERT_NEXT(a_fire_shows_result, core_fire, result_valid,
        "processed item did not reach the result register")

endmodule

@@ design/tsc_cfg_regs.sv @@
// Configuration registers of the TCP segmenter checksum unit and their derived sums.
// Depends on tsc_pkg.
module tsc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write,
    input  logic [tsc_pkg::CFG_INDEX_W-1:0]    index,
    input  logic [31:0]                        data,
    output tsc_pkg::cfg_view_t                 view
);

    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    tsc_pkg::cfg_view_t view_reg, view_next;

    // Derived sums are built from the written value so they are ready next cycle.
    always_comb
    begin
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        view_next     = view_reg;
        if (write)
        begin
            unique case (tsc_pkg::cfg_reg_t'(index))
                tsc_pkg::CFG_SRC_ADDR:
                begin
                    src_addr_next = data;
                    view_next.addr_sum = tsc_pkg::fold20(20'(data[31:16]) + 20'(data[15:0])
                        + 20'(dst_addr_reg[31:16]) + 20'(dst_addr_reg[15:0]));
                end
                tsc_pkg::CFG_DST_ADDR:
                begin
                    dst_addr_next = data;
                    view_next.addr_sum = tsc_pkg::fold20(20'(data[31:16]) + 20'(data[15:0])
                        + 20'(src_addr_reg[31:16]) + 20'(src_addr_reg[15:0]));
                end
                tsc_pkg::CFG_SRC_PORT:
                begin
                    src_port_next = data[15:0];
                    view_next.port_sum = tsc_pkg::fold20(20'(data[15:0]) + 20'(dst_port_reg));
                end
                tsc_pkg::CFG_DST_PORT:
                begin
                    dst_port_next = data[15:0];
                    view_next.port_sum = tsc_pkg::fold20(20'(data[15:0]) + 20'(src_port_reg));
                end
                tsc_pkg::CFG_LINK_MTU:
                begin
                    view_next.mp_base = tsc_pkg::mtu_eff(data[15:0]) - tsc_pkg::HDRS_BASE;
                    view_next.mp_opt  = tsc_pkg::mtu_eff(data[15:0]) - tsc_pkg::HDRS_OPT;
                end
                default:
                begin
                    view_next = view_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg      <= '0;
            dst_addr_reg      <= '0;
            src_port_reg      <= '0;
            dst_port_reg      <= '0;
            view_reg.addr_sum <= '0;
            view_reg.port_sum <= '0;
            view_reg.mp_base  <= tsc_pkg::MTU_DEFAULT - tsc_pkg::HDRS_BASE;
            view_reg.mp_opt   <= tsc_pkg::MTU_DEFAULT - tsc_pkg::HDRS_OPT;
        end
        else
        begin
            src_addr_reg <= src_addr_next;
            dst_addr_reg <= dst_addr_next;
            src_port_reg <= src_port_next;
            dst_port_reg <= dst_port_next;
            view_reg     <= view_next;
        end
    end

    assign view = view_reg;

endmodule

@@ design/tsc_in_reg.sv @@
// Input register of the TCP segmenter checksum unit; presums the per-message header words.
// Depends on tsc_pkg.
module tsc_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  tsc_pkg::item_t     item,
    input  logic               out_free,
    output logic               stage_valid,
    output tsc_pkg::stage_t    stage
);

    logic            valid_reg, valid_next;
    tsc_pkg::stage_t stage_reg, stage_next;
    logic            take;

    assign item_stall = valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        stage_next = stage_reg;
        valid_next = valid_reg;
        if (take)
        begin
            stage_next.item     = item;
            stage_next.word_sum = 18'(item.ack_number[31:16]) + 18'(item.ack_number[15:0])
                + 18'(item.window_size) + 18'(item.tcp_flag_bits);
            valid_next = 1'b1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

@@ design/tsc_seg_core.sv @@
// Segment state, length and checksum logic, and result register of the segmenter.
// Depends on tsc_pkg.
module tsc_seg_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  tsc_pkg::stage_t     stage,
    input  tsc_pkg::cfg_view_t  cfg,
    output tsc_pkg::result_t    result
);

    logic        in_msg_reg, in_msg_next;
    logic        first_reg, first_next;
    logic        mss_req_reg, mss_req_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] psum_reg, psum_next;
    logic [31:0] seq_reg, seq_next;
    logic [17:0] words_reg, words_next;
    tsc_pkg::result_t result_reg, result_next;

    logic        starting;
    logic        present;
    logic        last;
    logic        idle_item;
    logic        mss_req;
    logic        first;
    logic        opt;
    logic        close;
    logic [15:0] count_base;
    logic [15:0] count_after;
    logic [15:0] psum_base;
    logic [15:0] psum_new;
    logic [15:0] byte_word;
    logic [31:0] seq_eff;
    logic [17:0] words_eff;
    logic [15:0] mp;
    logic [16:0] tcp_len;
    logic [15:0] total;
    logic [2:0]  doff;
    logic [16:0] opt_word;
    logic [19:0] ip_raw;
    logic [19:0] tcp_raw;

    always_comb
    begin
        starting  = !in_msg_reg;
        present   = stage.item.byte_present;
        last      = stage.item.last_byte;
        idle_item = starting && !present && !last;

        mss_req    = starting ? stage.item.add_mss_option : mss_req_reg;
        first      = starting || first_reg;
        count_base = starting ? 16'h0 : count_reg;
        psum_base  = starting ? 16'h0 : psum_reg;
        seq_eff    = starting ? stage.item.start_sequence : seq_reg;
        words_eff  = starting ? stage.word_sum : words_reg;
        mp         = mss_req ? cfg.mp_opt : cfg.mp_base;

        // Even byte offsets land in the high half of a checksum word.
        byte_word   = count_base[0] ? {8'h00, stage.item.data_byte}
                                    : {stage.item.data_byte, 8'h00};
        count_after = present ? count_base + 16'd1 : count_base;
        psum_new    = present ? tsc_pkg::oc_add16(psum_base, byte_word) : psum_base;
        close       = last || (present && (count_after >= mp));

        opt      = first && mss_req;
        tcp_len  = {1'b0, count_after}
                 + {1'b0, (opt ? tsc_pkg::TCP_HDR_OPT : tsc_pkg::TCP_HDR_BASE)};
        total    = tcp_len[15:0] + tsc_pkg::IP_HDR_LEN;
        doff     = opt ? tsc_pkg::DOFF_OPT : tsc_pkg::DOFF_BASE;
        opt_word = opt ? ({1'b0, tsc_pkg::MSS_KIND_LEN} + {1'b0, mp}) : 17'h0;

        ip_raw  = 20'(tsc_pkg::IP_VER_IHL) + 20'(tsc_pkg::IP_TTL_PROTO)
                + 20'(total) + 20'(cfg.addr_sum);
        tcp_raw = 20'(cfg.addr_sum) + 20'(tsc_pkg::TCP_PROTO) + 20'(tcp_len)
                + 20'(cfg.port_sum) + 20'(seq_eff[31:16]) + 20'(seq_eff[15:0])
                + 20'(words_eff) + 20'({doff, 12'h000}) + 20'(opt_word) + 20'(psum_new);

        result_next                  = '0;
        result_next.out_byte         = present ? stage.item.data_byte : 8'h00;
        result_next.out_byte_present = present;
        if (close)
        begin
            result_next.segment_end        = 1'b1;
            result_next.message_end        = last;
            result_next.ip_total_length    = total;
            result_next.ip_header_checksum = ~tsc_pkg::fold20(ip_raw);
            result_next.tcp_checksum       = ~tsc_pkg::fold20(tcp_raw);
            result_next.segment_sequence   = seq_eff;
            result_next.data_offset_words  = doff;
            result_next.mss_value          = mp;
        end
    end

    // Segment state; an idle item outside a message leaves it untouched.
    always_comb
    begin
        in_msg_next  = in_msg_reg;
        first_next   = first_reg;
        mss_req_next = mss_req_reg;
        count_next   = count_reg;
        psum_next    = psum_reg;
        seq_next     = seq_reg;
        words_next   = words_reg;
        if (fire && !idle_item)
        begin
            mss_req_next = mss_req;
            words_next   = words_eff;
            if (close)
            begin
                in_msg_next = !last;
                first_next  = 1'b0;
                count_next  = 16'h0;
                psum_next   = 16'h0;
                seq_next    = seq_eff + 32'(count_after);
            end
            else
            begin
                in_msg_next = 1'b1;
                first_next  = first;
                count_next  = count_after;
                psum_next   = psum_new;
                seq_next    = seq_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg  <= 1'b0;
            first_reg   <= 1'b1;
            mss_req_reg <= 1'b0;
            count_reg   <= '0;
            psum_reg    <= '0;
            seq_reg     <= '0;
            words_reg   <= '0;
        end
        else
        begin
            in_msg_reg  <= in_msg_next;
            first_reg   <= first_next;
            mss_req_reg <= mss_req_next;
            count_reg   <= count_next;
            psum_reg    <= psum_next;
            seq_reg     <= seq_next;
            words_reg   <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
